// ===== rtl/image_conv3x3_valid_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef IMAGE_CONV3X3_VALID_UNIT_DEFINES_SVH
`define IMAGE_CONV3X3_VALID_UNIT_DEFINES_SVH

// Checked only outside reset.
`define ICV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ICV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/icv_pkg.sv =====
`default_nettype none

package icv_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int SUM_W       = 21;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd4;

    localparam logic [CFG_DATA_W-1:0] COEF_TOP_RST    = 24'h00FF00;
    localparam logic [CFG_DATA_W-1:0] COEF_MIDDLE_RST = 24'hFF05FF;
    localparam logic [CFG_DATA_W-1:0] COEF_BOTTOM_RST = 24'h00FF00;
    localparam logic [DIM_W-1:0]      WIDTH_RST       = 11'd640;
    localparam logic [DIM_W-1:0]      HEIGHT_RST      = 11'd480;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } icv_in_t;

    typedef struct packed {
        logic [7:0]       out_pixel;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } icv_out_t;

    // [row][col], row 0 is the oldest line, col 0 the oldest column
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] icv_win_t;
    typedef logic [KERNEL_SIZE-1:0][CFG_DATA_W-1:0]       icv_coef_t;

endpackage

`default_nettype wire

// ===== rtl/image_conv3x3_valid_unit.sv =====
// 3x3 valid-region convolution over an 8-bit grayscale raster stream. Pixels
// enter on in_data with frame_start on the first pixel of a frame; one result
// leaves on out_data for each pixel at input row >= 2 and column >= 2, so a
// W x H frame gives (W-2) x (H-2) results, frame_last set on the final one.
// The kernel is not flipped: coefficient byte 0 of each row register weighs
// the leftmost column, the top row register weighs the oldest line. The sum is
// clamped to 0..255. Throughput is one pixel per clock unless a result-producing
// pixel waits on out_ready; a result enters the output register when its pixel
// leaves the input register: the accepting edge loads the input register with
// the registered read of the two line stores, and the multiply-add acts on these
// combinationally. While a result waits on out_ready, pixels giving no result are
// still taken; a result-producing pixel in the input register holds in_ready low.
// The line stores are not cleared after reset, so the first two lines of the
// first frame must be streamed before results are meaningful, as in normal use.
// Width is taken clamped to 3..MAX_WIDTH and height to 3..1024; write the
// configuration registers only while no pixel is in flight.
`default_nettype none

module image_conv3x3_valid_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire icv_pkg::icv_in_t             in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output icv_pkg::icv_out_t                 out_data,
    input  wire logic                         cfg_we,
    input  wire logic [icv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [icv_pkg::CFG_DATA_W-1:0] cfg_data
);

    import icv_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    // configuration
    icv_coef_t        coef_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= COEF_TOP_RST;
            coef_reg[1] <= COEF_MIDDLE_RST;
            coef_reg[2] <= COEF_BOTTOM_RST;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_TOP:    coef_reg[0] <= cfg_data;
                CFG_COEF_MIDDLE: coef_reg[1] <= cfg_data;
                CFG_COEF_BOTTOM: coef_reg[2] <= cfg_data;
                CFG_WIDTH:       width_reg   <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:      height_reg  <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [LW-1:0]    width_ext;
    logic [LW-1:0]    w_use;
    logic [DIM_W-1:0] h_use;

    always_comb
    begin
        width_ext = LW'(width_reg);
        if (width_ext < LW'(3))
            w_use = LW'(3);
        else if (width_ext > LW'(MAX_WIDTH))
            w_use = LW'(MAX_WIDTH);
        else
            w_use = width_ext;

        if (height_reg < DIM_W'(3))
            h_use = DIM_W'(3);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_use = DIM_W'(MAX_HEIGHT);
        else
            h_use = height_reg;
    end

    // position counters, advanced on every accepted word
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [POS_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    cur_col;
    logic [POS_W-1:0] cur_row;
    logic             line_end;
    logic             frame_end;
    logic             in_accept;

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        cur_col   = in_data.frame_start ? '0 : col_count_reg;
        cur_row   = in_data.frame_start ? '0 : row_count_reg;
        line_end  = (LW'(cur_col) + LW'(1)) >= w_use;
        frame_end = line_end && ((DIM_W'(cur_row) + DIM_W'(1)) >= h_use);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept)
        begin
            if (line_end)
            begin
                col_count_next = '0;
                row_count_next = frame_end ? '0 : POS_W'(cur_row + POS_W'(1));
            end
            else
            begin
                col_count_next = CW'(cur_col + CW'(1));
                row_count_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // input stage: waits here for the line-store read
    logic             s1_valid_reg;
    logic [7:0]       s1_px_reg;
    logic [CW-1:0]    s1_idx_reg;
    logic             s1_result_reg;
    logic [POS_W-1:0] s1_row_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic             s1_last_reg;
    logic             commit;
    logic [LW-1:0]    col_minus2;

    assign commit     = s1_valid_reg && (!s1_result_reg || !out_valid || out_ready);
    assign in_ready   = !s1_valid_reg || commit;
    assign col_minus2 = LW'(cur_col) - LW'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg     <= in_data.pixel;
            s1_idx_reg    <= cur_col;
            s1_result_reg <= (cur_row >= POS_W'(2)) && (LW'(cur_col) >= LW'(2));
            s1_row_reg    <= POS_W'(cur_row - POS_W'(2));
            s1_col_reg    <= col_minus2[POS_W-1:0];
            s1_last_reg   <= frame_end;
        end
    end

    logic [7:0] up2;
    logic [7:0] up1;

    icv_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (cur_col),
        .wr_en   (commit),
        .wr_addr (s1_idx_reg),
        .wr_up2  (up1),
        .wr_up1  (s1_px_reg),
        .rd_up2  (up2),
        .rd_up1  (up1)
    );

    // window: shift left, newest column on the right
    icv_win_t win_reg, win_next;

    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = up2;
        win_next[1][2] = up1;
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (commit)
            win_reg <= win_next;
    end

    logic [7:0] sat_pixel;

    icv_mac u_mac (
        .win       (win_next),
        .coef      (coef_reg),
        .sat_pixel (sat_pixel)
    );

    // output register
    logic     out_valid_reg;
    icv_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit && s1_result_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit && s1_result_reg)
        begin
            out_data_reg.out_pixel  <= sat_pixel;
            out_data_reg.out_row    <= s1_row_reg;
            out_data_reg.out_col    <= s1_col_reg;
            out_data_reg.frame_last <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/icv_line_buf.sv =====
`default_nettype none

module icv_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [CW-1:0] rd_addr,
    input  wire logic          wr_en,
    input  wire logic [CW-1:0] wr_addr,
    input  wire logic [7:0]    wr_up2,
    input  wire logic [7:0]    wr_up1,
    output logic      [7:0]    rd_up2,
    output logic      [7:0]    rd_up1
);

    // line two rows back and line one row back
    logic [7:0] mem_a_reg [MAX_WIDTH];
    logic [7:0] mem_b_reg [MAX_WIDTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a_reg[wr_addr] <= wr_up2;
            mem_b_reg[wr_addr] <= wr_up1;
        end
    end

    // forward the word being written when the read hits the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_a_reg <= wr_up2;
                rd_b_reg <= wr_up1;
            end
            else
            begin
                rd_a_reg <= mem_a_reg[rd_addr];
                rd_b_reg <= mem_b_reg[rd_addr];
            end
        end
    end

    assign rd_up2 = rd_a_reg;
    assign rd_up1 = rd_b_reg;

endmodule

`default_nettype wire

// ===== rtl/icv_mac.sv =====
`default_nettype none

module icv_mac (
    input  wire icv_pkg::icv_win_t  win,
    input  wire icv_pkg::icv_coef_t coef,
    output logic [7:0]              sat_pixel
);

    import icv_pkg::*;

    logic signed [16:0]      prod [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [18:0]      row_sum [KERNEL_SIZE];
    logic signed [SUM_W-1:0] total;

    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int j = 0; j < KERNEL_SIZE; j++)
            begin
                prod[i][j] = $signed({1'b0, win[i][j]}) * $signed(coef[i][8*j +: 8]);
            end
            row_sum[i] = 19'(prod[i][0]) + 19'(prod[i][1]) + 19'(prod[i][2]);
        end
        total = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
    end

    // clamp to 0..255
    always_comb
    begin
        if (total < 0)
            sat_pixel = 8'd0;
        else if (total > SUM_W'(255))
            sat_pixel = 8'd255;
        else
            sat_pixel = total[7:0];
    end

endmodule

`default_nettype wire

// ===== rtl/icv_checker.sv =====
`default_nettype none
`include "image_conv3x3_valid_unit_defines.svh"

module icv_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire icv_pkg::icv_out_t out_data
);

    import icv_pkg::*;

    `ICV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")

    `ICV_ASSERT_ALWAYS(a_reset_idle, $rose(rst_n) |-> !out_valid, "result offered right after reset")

    `ICV_ASSERT(a_col_step, out_valid && out_ready && $past(out_valid && out_ready) |-> (out_data.out_col == 10'($past(out_data.out_col) + 10'd1)) || (out_data.out_col == '0), "result columns not in sequence")

endmodule

bind image_conv3x3_valid_unit icv_checker u_icv_checker (.*);

`default_nettype wire

// ===== test/tb_image_conv3x3_valid_unit.sv =====
`timescale 1ns / 1ps

module tb_image_conv3x3_valid_unit;

    import icv_pkg::*;

    localparam int FRAME_MAX_W   = 1024;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int REPORT_LIMIT  = 10;

    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {COEF_ANY, COEF_SMALL, COEF_RAILS} coef_mix_t;
    typedef enum int {PIX_ANY, PIX_RAILS, PIX_DIM} pix_mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    icv_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    icv_out_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror and filter state
    logic [CFG_DATA_W-1:0] coef_rows [KERNEL_SIZE];
    logic [DIM_W-1:0]      img_width;
    logic [DIM_W-1:0]      img_height;
    logic [7:0]            line_mem [2*FRAME_MAX_W];
    logic [7:0]            win [KERNEL_SIZE][KERNEL_SIZE];
    int                    pos_col = 0;
    int                    pos_row = 0;

    icv_in_t  pix_queue [$];
    icv_out_t conv_expect [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  in_taken = 1'b0;
    int  items_queued = 0;
    int  words_checked = 0;
    int  frames_closed = 0;
    int  clip_high = 0;
    int  clip_low = 0;
    int  mismatches = 0;

    image_conv3x3_valid_unit #(
        .MAX_WIDTH (FRAME_MAX_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int dim_clamp(logic [DIM_W-1:0] raw, int hi);
        if (raw < 3)
            return 3;
        if (raw > hi)
            return hi;
        return int'(raw);
    endfunction

    function automatic void conv_predict(icv_in_t word);
        int         eff_w;
        int         eff_h;
        int         col;
        int         row;
        int         sum;
        logic [7:0] up2;
        logic [7:0] up1;
        byte        wgt;
        bit         line_end;
        bit         frame_end;
        icv_out_t   res;
        eff_w = dim_clamp(img_width, FRAME_MAX_W);
        eff_h = dim_clamp(img_height, MAX_HEIGHT);
        if (word.frame_start)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        col = pos_col;
        row = pos_row;
        up2 = line_mem[col];
        up1 = line_mem[FRAME_MAX_W + col];
        line_mem[col] = up1;
        line_mem[FRAME_MAX_W + col] = word.pixel;
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = word.pixel;
        line_end = (col + 1 >= eff_w);
        frame_end = line_end && (row + 1 >= eff_h);
        if (row >= 2 && col >= 2)
        begin
            sum = 0;
            for (int i = 0; i < KERNEL_SIZE; i++)
                for (int j = 0; j < KERNEL_SIZE; j++)
                begin
                    wgt = coef_rows[i][8*j +: 8];
                    sum += int'(win[i][j]) * int'(wgt);
                end
            if (sum > 255)
            begin
                sum = 255;
                clip_high++;
            end
            else if (sum < 0)
            begin
                sum = 0;
                clip_low++;
            end
            res.out_pixel  = sum[7:0];
            res.out_row    = POS_W'(row - 2);
            res.out_col    = POS_W'(col - 2);
            res.frame_last = frame_end;
            conv_expect.push_back(res);
        end
        if (line_end)
        begin
            pos_col = 0;
            pos_row = frame_end ? 0 : row + 1;
        end
        else
            pos_col = col + 1;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef(coef_mix_t mix);
        logic [CFG_DATA_W-1:0] packed_row;
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            if (mix == COEF_ANY)
                packed_row[8*k +: 8] = 8'($urandom);
            else if (mix == COEF_SMALL)
                packed_row[8*k +: 8] = 8'($urandom_range(8)) - 8'd4;
            else
                case ($urandom_range(4))
                    0: packed_row[8*k +: 8] = 8'h80;
                    1: packed_row[8*k +: 8] = 8'h7F;
                    2: packed_row[8*k +: 8] = 8'hFF;
                    3: packed_row[8*k +: 8] = 8'h01;
                    default: packed_row[8*k +: 8] = 8'h00;
                endcase
        end
        return packed_row;
    endfunction

    function automatic logic [7:0] pick_pixel(pix_mix_t mix);
        if (mix == PIX_RAILS)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        if (mix == PIX_DIM)
            return 8'($urandom_range(15));
        return 8'($urandom);
    endfunction

    task automatic queue_word(logic [7:0] px, bit fs);
        icv_in_t word;
        word.pixel = px;
        word.frame_start = fs;
        pix_queue.push_back(word);
        items_queued++;
    endtask

    // noisy frames get a stray frame_start now and then
    task automatic queue_frame(bit lead_start, int count, pix_mix_t mix, bit noisy);
        for (int n = 0; n < count; n++)
            queue_word(pick_pixel(mix),
                       (n == 0) ? lead_start : (noisy && $urandom_range(63) == 0));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_COEF_TOP:    coef_rows[0] = value;
            CFG_COEF_MIDDLE: coef_rows[1] = value;
            CFG_COEF_BOTTOM: coef_rows[2] = value;
            CFG_WIDTH:       img_width = value[DIM_W-1:0];
            CFG_HEIGHT:      img_height = value[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every word to drain, then let result-less pixels clear the pipe
    task automatic settle();
        while (pix_queue.size() != 0 || in_valid || conv_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int sidle, int rstall, int target);
        int               first_item;
        int               block_first;
        int               cols;
        int               rows;
        int               kind;
        bit               aligned;
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        pix_mix_t         pmix;
        coef_mix_t        cmix;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        first_item = items_queued;
        while (items_queued - first_item < target)
        begin
            settle();
            cmix = coef_mix_t'($urandom_range(2));
            write_reg(CFG_COEF_TOP, rand_coef(cmix));
            write_reg(CFG_COEF_MIDDLE, rand_coef(cmix));
            write_reg(CFG_COEF_BOTTOM, rand_coef(cmix));
            case ($urandom_range(9))
                0: w_raw = DIM_W'($urandom_range(2));
                1: w_raw = DIM_W'($urandom_range(40, 11));
                default: w_raw = DIM_W'($urandom_range(10, 3));
            endcase
            case ($urandom_range(9))
                0: h_raw = DIM_W'($urandom_range(2));
                1: h_raw = DIM_W'($urandom_range(12, 7));
                default: h_raw = DIM_W'($urandom_range(6, 3));
            endcase
            // upper data bits are don't-care for the dimension registers
            write_reg(CFG_WIDTH, {13'($urandom), w_raw});
            write_reg(CFG_HEIGHT, {13'($urandom), h_raw});
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            end_writes();
            cols = dim_clamp(w_raw, FRAME_MAX_W);
            rows = dim_clamp(h_raw, MAX_HEIGHT);
            aligned = 1'b0;
            block_first = items_queued;
            while (items_queued - block_first < 60)
            begin
                kind = $urandom_range(9);
                pmix = pix_mix_t'($urandom_range(2));
                if (kind == 7)
                begin
                    queue_frame(1'b1, $urandom_range(cols * rows - 1, 1), pmix, 1'b0);
                    aligned = 1'b0;
                end
                else if (kind >= 8)
                begin
                    queue_frame(1'b1, cols * rows, pmix, 1'b1);
                    aligned = 1'b0;
                end
                else
                begin
                    // after a clean frame, let the row counter wrap on its own
                    queue_frame(aligned ? 1'($urandom_range(1)) : 1'b1,
                                cols * rows, pmix, 1'b0);
                    aligned = 1'b1;
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pix_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        icv_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (conv_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected out word pix=%0d row=%0d col=%0d last=%0d",
                             $time, out_data.out_pixel, out_data.out_row,
                             out_data.out_col, out_data.frame_last);
            end
            else
            begin
                want = conv_expect.pop_front();
                words_checked++;
                if (want.frame_last)
                    frames_closed++;
                if (out_data.out_pixel !== want.out_pixel
                    || out_data.out_row !== want.out_row
                    || out_data.out_col !== want.out_col
                    || out_data.frame_last !== want.frame_last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: out word expected pix=%0d row=%0d col=%0d last=%0d, %s",
                                 $time, want.out_pixel, want.out_row, want.out_col,
                                 want.frame_last,
                                 $sformatf("got pix=%0d row=%0d col=%0d last=%0d",
                                           out_data.out_pixel, out_data.out_row,
                                           out_data.out_col, out_data.frame_last));
                end
            end
        end
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
            conv_predict(in_data);
    end

    initial
    begin
        #20_000_000;
        $display("Run timed out at %0t with %0d words outstanding", $time,
                 conv_expect.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [7:0] sharp_pat [12];
        logic [7:0] rail_pat [9];
        sharp_pat = '{8'd0, 8'd0, 8'd255, 8'd0,
                      8'd0, 8'd255, 8'd0, 8'd255,
                      8'd0, 8'd0, 8'd255, 8'd0};
        rail_pat = '{8'd255, 8'd1, 8'd128,
                     8'd127, 8'd254, 8'd0,
                     8'd2, 8'd64, 8'd255};
        coef_rows[0] = COEF_TOP_RST;
        coef_rows[1] = COEF_MIDDLE_RST;
        coef_rows[2] = COEF_BOTTOM_RST;
        img_width = WIDTH_RST;
        img_height = HEIGHT_RST;
        for (int k = 0; k < 2*FRAME_MAX_W; k++)
            line_mem[k] = '0;
        for (int i = 0; i < KERNEL_SIZE; i++)
            for (int j = 0; j < KERNEL_SIZE; j++)
                win[i][j] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset kernel on a 4x3 frame: one word clips high, the next clips low
        write_reg(CFG_WIDTH, 24'd4);
        write_reg(CFG_HEIGHT, 24'd3);
        end_writes();
        foreach (sharp_pat[k])
            queue_word(sharp_pat[k], 1'b0);
        settle();

        // extreme weights, dimensions below the minimum, ignored index
        write_reg(CFG_COEF_TOP, 24'h807F80);
        write_reg(CFG_COEF_MIDDLE, 24'h7F807F);
        write_reg(CFG_COEF_BOTTOM, 24'hFF0180);
        write_reg(CFG_WIDTH, 24'd0);
        write_reg(CFG_HEIGHT, 24'd1);
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        end_writes();
        foreach (rail_pat[k])
            queue_word(rail_pat[k], 1'b1 && k == 0);
        settle();

        run_phase(0, 0, 325);
        run_phase(68, 0, 325);
        run_phase(0, 68, 325);
        run_phase(24, 24, 325);
        settle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Streamed %0d pixels through frames up to 40 wide and 12 tall %s",
                 items_queued, "under four handshake pressure mixes.");
        $display("Checked %0d filtered words, %0d frame ends, %0d clipped high, %0d low.",
                 words_checked, frames_closed, clip_high, clip_low);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== image_conv3x3_valid_unit.f =====
+incdir+rtl
rtl/icv_pkg.sv
rtl/icv_line_buf.sv
rtl/icv_mac.sv
rtl/image_conv3x3_valid_unit.sv
rtl/icv_checker.sv
test/tb_image_conv3x3_valid_unit.sv
